### rtl/core/cgf_pkg.sv
// Shared widths, constants and types for the complex gammatone filter core.
// No dependencies; every other file in rtl/core takes what it needs from here.
package cgf_pkg;

   localparam int CGF_STAGES   = 4;
   localparam int CGF_CAPACITY = CGF_STAGES + 3;

   localparam int SAMPLE_W   = 24;
   localparam int REG_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int STATE_W    = 48;
   localparam int HALF_W     = STATE_W / 2;
   localparam int OPER_W     = REG_W + 1;
   localparam int PART_W     = HALF_W + 1 + OPER_W;
   localparam int FULL_W     = STATE_W + OPER_W;
   localparam int COEF_SHIFT = 30;
   localparam int GAIN_SHIFT = 46;
   localparam int TERM_W     = FULL_W - COEF_SHIFT;
   localparam int SUM_W      = TERM_W + 1;
   localparam int OUT_TERM_W = FULL_W - GAIN_SHIFT;

   localparam logic signed [FULL_W-1:0] COEF_RND =
      {{(FULL_W - COEF_SHIFT){1'b0}}, 1'b1, {(COEF_SHIFT - 1){1'b0}}};
   localparam logic signed [FULL_W-1:0] GAIN_RND =
      {{(FULL_W - GAIN_SHIFT){1'b0}}, 1'b1, {(GAIN_SHIFT - 1){1'b0}}};

   // stage value limit is +-(2^47 - 1)
   localparam logic signed [SUM_W-1:0] STATE_MAX =
      {{(SUM_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] STATE_MIN =
      {{(SUM_W - STATE_W + 1){1'b1}}, {(STATE_W - 2){1'b0}}, 1'b1};

   localparam logic signed [OUT_TERM_W-1:0] OUT_MAX =
      {{(OUT_TERM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [OUT_TERM_W-1:0] OUT_MIN =
      {{(OUT_TERM_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_REAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_IMAG = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = 2'd2;

   typedef enum logic [1:0] {
      PH_LOW,
      PH_HIGH,
      PH_SUM,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      advance;
   } ctrl_type;

   typedef struct packed {
      logic                      valid;
      logic                      clip;
      logic signed [STATE_W-1:0] re;
      logic signed [STATE_W-1:0] im;
   } link_type;

endpackage

### rtl/core/cgf_if.sv
// Request and response channel interfaces of the complex gammatone filter core.
// Depends on cgf_pkg for the payload widths.
interface cgf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cgf_pkg::SAMPLE_W-1:0]   sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface cgf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cgf_pkg::SAMPLE_W-1:0]   real_out;
   logic signed [cgf_pkg::SAMPLE_W-1:0]   imag_out;
   logic                                  clipped;

   modport source (output valid, output real_out, output imag_out, output clipped,
                   input ready);
   modport sink   (input valid, input real_out, input imag_out, input clipped,
                   output ready);
endinterface

### rtl/core/cgf_mul.sv
// Two-pass 48 x 33 signed multiplier with rounding offset, driven by the cell phase.
// Depends on cgf_pkg.
module cgf_mul (
   input  logic                                clock,
   input  cgf_pkg::phase_type                  phase,
   input  logic signed [cgf_pkg::STATE_W-1:0]  a,
   input  logic signed [cgf_pkg::OPER_W-1:0]   b,
   input  logic signed [cgf_pkg::FULL_W-1:0]   rnd,
   output logic signed [cgf_pkg::FULL_W-1:0]   prod
);
   import cgf_pkg::*;

   logic signed [HALF_W:0]     half;
   logic signed [PART_W-1:0]   part;
   logic signed [PART_W-1:0]   lo_ff;
   logic signed [PART_W-1:0]   hi_ff;
   logic signed [FULL_W-1:0]   prod_ff;

   // low half goes in unsigned, high half carries the sign
   always_comb begin
      if (phase == PH_LOW) begin
         half = $signed({1'b0, a[HALF_W-1:0]});
      end else begin
         half = $signed({a[STATE_W-1], a[STATE_W-1:HALF_W]});
      end
      part = half * b;
   end

   always_ff @(posedge clock) begin
      case (phase)
         PH_LOW: begin
            lo_ff <= part;
         end
         PH_HIGH: begin
            hi_ff <= part;
         end
         PH_SUM: begin
            prod_ff <= ({{(FULL_W - PART_W){hi_ff[PART_W-1]}}, hi_ff} << HALF_W)
                     + {{(FULL_W - PART_W){lo_ff[PART_W-1]}}, lo_ff} + rnd;
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign prod = prod_ff;

endmodule

### rtl/core/cgf_stage_cell.sv
// One complex one-pole stage of the chain: holds its state, takes the value from
// the previous cell and hands its new value on. Depends on cgf_pkg and cgf_mul.
module cgf_stage_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  cgf_pkg::ctrl_type                   ctrl,
   input  logic signed [cgf_pkg::OPER_W-1:0]   coef_re,
   input  logic signed [cgf_pkg::OPER_W-1:0]   coef_im,
   input  cgf_pkg::link_type                   link_in,
   output cgf_pkg::link_type                   link_out
);
   import cgf_pkg::*;

   logic                       in_valid_ff;
   logic                       in_clip_ff;
   logic signed [STATE_W-1:0]  in_re_ff;
   logic signed [STATE_W-1:0]  in_im_ff;
   logic signed [STATE_W-1:0]  state_re_ff;
   logic signed [STATE_W-1:0]  state_im_ff;

   logic signed [FULL_W-1:0]   p_rr;
   logic signed [FULL_W-1:0]   p_ii;
   logic signed [FULL_W-1:0]   p_ir;
   logic signed [FULL_W-1:0]   p_ri;
   logic signed [TERM_W-1:0]   t_rr;
   logic signed [TERM_W-1:0]   t_ii;
   logic signed [TERM_W-1:0]   t_ir;
   logic signed [TERM_W-1:0]   t_ri;
   logic signed [SUM_W-1:0]    sum_re;
   logic signed [SUM_W-1:0]    sum_im;
   logic signed [STATE_W-1:0]  new_re;
   logic signed [STATE_W-1:0]  new_im;
   logic                       clip_re;
   logic                       clip_im;

   cgf_mul u_mul_rr (.clock(clock), .phase(ctrl.phase), .a(state_re_ff), .b(coef_re),
                     .rnd(COEF_RND), .prod(p_rr));
   cgf_mul u_mul_ii (.clock(clock), .phase(ctrl.phase), .a(state_im_ff), .b(coef_im),
                     .rnd(COEF_RND), .prod(p_ii));
   cgf_mul u_mul_ir (.clock(clock), .phase(ctrl.phase), .a(state_im_ff), .b(coef_re),
                     .rnd(COEF_RND), .prod(p_ir));
   cgf_mul u_mul_ri (.clock(clock), .phase(ctrl.phase), .a(state_re_ff), .b(coef_im),
                     .rnd(COEF_RND), .prod(p_ri));

   always_comb begin
      t_rr = p_rr[FULL_W-1:COEF_SHIFT];
      t_ii = p_ii[FULL_W-1:COEF_SHIFT];
      t_ir = p_ir[FULL_W-1:COEF_SHIFT];
      t_ri = p_ri[FULL_W-1:COEF_SHIFT];

      sum_re = {{(SUM_W - STATE_W){in_re_ff[STATE_W-1]}}, in_re_ff}
             + {{(SUM_W - TERM_W){t_rr[TERM_W-1]}}, t_rr}
             - {{(SUM_W - TERM_W){t_ii[TERM_W-1]}}, t_ii};
      sum_im = {{(SUM_W - STATE_W){in_im_ff[STATE_W-1]}}, in_im_ff}
             + {{(SUM_W - TERM_W){t_ir[TERM_W-1]}}, t_ir}
             + {{(SUM_W - TERM_W){t_ri[TERM_W-1]}}, t_ri};

      clip_re = 1'b1;
      if (sum_re > STATE_MAX) begin
         new_re = STATE_MAX[STATE_W-1:0];
      end else if (sum_re < STATE_MIN) begin
         new_re = STATE_MIN[STATE_W-1:0];
      end else begin
         new_re  = sum_re[STATE_W-1:0];
         clip_re = 1'b0;
      end

      clip_im = 1'b1;
      if (sum_im > STATE_MAX) begin
         new_im = STATE_MAX[STATE_W-1:0];
      end else if (sum_im < STATE_MIN) begin
         new_im = STATE_MIN[STATE_W-1:0];
      end else begin
         new_im  = sum_im[STATE_W-1:0];
         clip_im = 1'b0;
      end

      link_out = '{valid: in_valid_ff, clip: in_clip_ff | clip_re | clip_im,
                   re: new_re, im: new_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_re_ff <= '0;
         state_im_ff <= '0;
      end else if (ctrl.advance) begin
         in_valid_ff <= link_in.valid;
         in_clip_ff  <= link_in.clip;
         in_re_ff    <= link_in.re;
         in_im_ff    <= link_in.im;
         // bubbles pass through without touching the state
         if (in_valid_ff) begin
            state_re_ff <= new_re;
            state_im_ff <= new_im;
         end
      end
   end

endmodule

### rtl/core/cgf_out_cell.sv
// End cell of the chain: scales the last stage by the gain, saturates to 24 bits
// and holds the result register of the response channel. Depends on cgf_pkg, cgf_mul.
module cgf_out_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cgf_pkg::ctrl_type                    ctrl,
   input  logic signed [cgf_pkg::OPER_W-1:0]    gain,
   input  cgf_pkg::link_type                    link_in,
   input  logic                                 rsp_ready,
   output logic                                 busy,
   output logic                                 rsp_valid,
   output logic signed [cgf_pkg::SAMPLE_W-1:0]  real_out,
   output logic signed [cgf_pkg::SAMPLE_W-1:0]  imag_out,
   output logic                                 clipped
);
   import cgf_pkg::*;

   logic                          in_valid_ff;
   logic                          in_clip_ff;
   logic signed [STATE_W-1:0]     in_re_ff;
   logic signed [STATE_W-1:0]     in_im_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]    real_out_ff;
   logic signed [SAMPLE_W-1:0]    imag_out_ff;
   logic                          clipped_ff;

   logic signed [FULL_W-1:0]      p_re;
   logic signed [FULL_W-1:0]      p_im;
   logic signed [OUT_TERM_W-1:0]  o_re;
   logic signed [OUT_TERM_W-1:0]  o_im;
   logic signed [SAMPLE_W-1:0]    sat_re;
   logic signed [SAMPLE_W-1:0]    sat_im;
   logic                          clip_re;
   logic                          clip_im;

   cgf_mul u_mul_re (.clock(clock), .phase(ctrl.phase), .a(in_re_ff), .b(gain),
                     .rnd(GAIN_RND), .prod(p_re));
   cgf_mul u_mul_im (.clock(clock), .phase(ctrl.phase), .a(in_im_ff), .b(gain),
                     .rnd(GAIN_RND), .prod(p_im));

   always_comb begin
      o_re = p_re[FULL_W-1:GAIN_SHIFT];
      o_im = p_im[FULL_W-1:GAIN_SHIFT];

      clip_re = 1'b1;
      if (o_re > OUT_MAX) begin
         sat_re = OUT_MAX[SAMPLE_W-1:0];
      end else if (o_re < OUT_MIN) begin
         sat_re = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         sat_re  = o_re[SAMPLE_W-1:0];
         clip_re = 1'b0;
      end

      clip_im = 1'b1;
      if (o_im > OUT_MAX) begin
         sat_im = OUT_MAX[SAMPLE_W-1:0];
      end else if (o_im < OUT_MIN) begin
         sat_im = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         sat_im  = o_im[SAMPLE_W-1:0];
         clip_im = 1'b0;
      end
   end

   // hold the chain only when a finished item has nowhere to go
   assign busy = in_valid_ff && rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.advance) begin
            in_valid_ff <= link_in.valid;
            in_clip_ff  <= link_in.clip;
            in_re_ff    <= link_in.re;
            in_im_ff    <= link_in.im;
         end
         if (ctrl.advance && in_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            real_out_ff  <= sat_re;
            imag_out_ff  <= sat_im;
            clipped_ff   <= in_clip_ff | clip_re | clip_im;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign real_out  = real_out_ff;
   assign imag_out  = imag_out_ff;
   assign clipped   = clipped_ff;

endmodule

### rtl/core/complex_gammatone_filter_core.sv
// Top level of the complex gammatone filter: configuration registers, beat sequencer,
// input holding register and the chain of stage cells ending in the output cell.
// Depends on cgf_pkg, cgf_if, cgf_stage_cell and cgf_out_cell.
//
//   channel  | direction | handshake          | carries
//   ---------+-----------+--------------------+-----------------------------------
//   req_ch   | in        | valid / ready      | sample_in
//   rsp_ch   | out       | valid / ready      | real_out, imag_out, clipped
//   csr_*    | in        | csr_write, no wait | csr_index, csr_wdata
//
// Every cell works in beats: low and high halves of the operand pass through its
// 25 x 33 multipliers, the rounding add, then the sum and clamp handed onwards.
// Cells advance together, so at best one item is taken per beat; an item reaches
// rsp_ch through the holding register, the stage cells and the output cell.
// Synchronous reset clears coefficients, gain, stage states and all valid bits.
// A stalled rsp_ch holds the chain only once the output cell holds a finished item.
module complex_gammatone_filter_core (
   input  logic                                clock,
   input  logic                                reset,
   cgf_req_if.sink                             req_ch,
   cgf_rsp_if.source                           rsp_ch,
   input  logic                                csr_write,
   input  logic [cgf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cgf_pkg::REG_W-1:0]           csr_wdata
);
   import cgf_pkg::*;

   logic [REG_W-1:0]             coef_re_ff;
   logic [REG_W-1:0]             coef_im_ff;
   logic [REG_W-1:0]             gain_ff;
   phase_type                    phase_ff;
   phase_type                    phase_in;
   logic                         advance;
   logic                         busy;
   ctrl_type                     ctrl;
   logic                         hold_valid_ff;
   logic                         hold_valid_in;
   logic signed [SAMPLE_W-1:0]   hold_sample_ff;
   logic                         req_accept;
   logic signed [OPER_W-1:0]     coef_re_op;
   logic signed [OPER_W-1:0]     coef_im_op;
   logic signed [OPER_W-1:0]     gain_op;
   link_type                     links [CGF_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_re_ff <= '0;
         coef_im_ff <= '0;
         gain_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COEF_REAL: coef_re_ff <= csr_wdata;
            CSR_COEF_IMAG: coef_im_ff <= csr_wdata;
            CSR_GAIN:      gain_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign coef_re_op = $signed({coef_re_ff[REG_W-1], coef_re_ff});
   assign coef_im_op = $signed({coef_im_ff[REG_W-1], coef_im_ff});
   assign gain_op    = $signed({1'b0, gain_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LOW;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      advance  = 1'b0;
      phase_in = phase_ff;
      case (phase_ff)
         PH_LOW:  phase_in = PH_HIGH;
         PH_HIGH: phase_in = PH_SUM;
         PH_SUM:  phase_in = PH_DONE;
         PH_DONE: begin
            if (!busy) begin
               advance  = 1'b1;
               phase_in = PH_LOW;
            end
         end
         default: phase_in = PH_LOW;
      endcase
   end

   assign ctrl = '{phase: phase_ff, advance: advance};

   // holding register: free again when the chain takes its item
   assign req_ch.ready  = !hold_valid_ff || advance;
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign hold_valid_in = req_accept || (hold_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (req_accept) begin
            hold_sample_ff <= req_ch.sample_in;
         end
      end
   end

   always_comb begin
      links[0] = '{valid: hold_valid_ff, clip: 1'b0,
                   re: {{(STATE_W - SAMPLE_W - FRAC_W){hold_sample_ff[SAMPLE_W-1]}},
                        hold_sample_ff, {FRAC_W{1'b0}}},
                   im: '0};
   end

   for (genvar j = 0; j < CGF_STAGES; j++) begin : g_stage
      cgf_stage_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .coef_re  (coef_re_op),
         .coef_im  (coef_im_op),
         .link_in  (links[j]),
         .link_out (links[j+1])
      );
   end

   cgf_out_cell u_out (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .gain      (gain_op),
      .link_in   (links[CGF_STAGES]),
      .rsp_ready (rsp_ch.ready),
      .busy      (busy),
      .rsp_valid (rsp_ch.valid),
      .real_out  (rsp_ch.real_out),
      .imag_out  (rsp_ch.imag_out),
      .clipped   (rsp_ch.clipped)
   );

endmodule

### rtl/core/cgf_checker.sv
// Port-level checks for complex_gammatone_filter_core and the bind that attaches them.
// Depends on cgf_pkg and the top level.
module cgf_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [cgf_pkg::SAMPLE_W-1:0]  real_out,
   input  logic signed [cgf_pkg::SAMPLE_W-1:0]  imag_out,
   input  logic                                 clipped
);
   import cgf_pkg::*;

   localparam int CNT_W = $clog2(CGF_CAPACITY + 2);
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CGF_CAPACITY);

   logic             req_acc;
   logic             rsp_acc;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (req_acc && !rsp_acc) begin
         count_in = count_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(real_out) && $stable(imag_out)
                                  && $stable(clipped))
      else $error("result item changed or dropped while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("result item shown with no item outstanding");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_CAP)
      else $error("more items outstanding than the chain can hold");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item shown straight after reset");

endmodule

bind complex_gammatone_filter_core cgf_checker u_cgf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .real_out  (rsp_ch.real_out),
   .imag_out  (rsp_ch.imag_out),
   .clipped   (rsp_ch.clipped)
);
